// ===== hdl/icfl_pkg.sv =====
// Package for the ID card field locator: sizes, character codes, parse phases
// and result status codes. No dependencies.
`default_nettype none

package icfl_pkg;

	localparam int MAX_SUBFILE_BYTES = 16384;
	// Position counter saturates at MAX_SUBFILE_BYTES, so it must hold that value.
	localparam int POS_W = $clog2(MAX_SUBFILE_BYTES + 1);
	localparam int OUT_W = 14;
	localparam int NUM_IDENT = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7e;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] IDENT_RESET = 8'd65;

	localparam logic [CFG_IDX_W-1:0] REG_IDENT_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDENT_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDENT_THIRD = 2'd2;

	typedef enum logic [4:0] {
		PH_TYPE1 = 5'b00001,
		PH_TYPE2 = 5'b00010,
		PH_AFTER_TYPE = 5'b00100,
		PH_IDENT = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_INVALID = 2'd2,
		ST_BAD_IDENT = 2'd3
	} status_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/icfl_in_if.sv =====
// Input byte channel of the ID card field locator: valid/ready plus one
// subfile byte and its final flag. Depends on nothing.
`default_nettype none

interface icfl_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic is_final;

	modport source (output valid, output data_byte, output is_final, input ready);
	modport sink (input valid, input data_byte, input is_final, output ready);
endinterface

`default_nettype wire

// ===== hdl/icfl_out_if.sv =====
// Result channel of the ID card field locator: valid/ready plus status and
// the located field's offset and length. Depends on nothing.
`default_nettype none

interface icfl_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [13:0] match_start;
	logic [13:0] match_length;

	modport source (output valid, output status, output match_start,
		output match_length, input ready);
	modport sink (input valid, input status, input match_start,
		input match_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/icfl_cfg_if.sv =====
// Configuration write channel of the ID card field locator: valid/ready,
// register index and write data. Depends on nothing.
`default_nettype none

interface icfl_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/id_card_field_locator_core.sv =====
// ID card field locator top level: structure check and field search.
// Depends on icfl_pkg and the icfl_in_if, icfl_out_if, icfl_cfg_if interfaces.
// A final byte is held in the input register until a result slot is free, then loads the
// result register, which drives result valid.
// Throughput: 1 byte per cycle; a final byte holds while the previous result is unread.
// Reset (arst_n low, asynchronous): stream state cleared, identifiers set to "AAA".
`default_nettype none

module id_card_field_locator_core
	import icfl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	icfl_in_if.sink item,
	icfl_out_if.source result,
	icfl_cfg_if.sink cfg
);

	// Input stage
	logic valid_s1;
	logic [7:0] byte_s1;
	logic final_s1;

	// Identifier registers
	logic [7:0] ident_q [NUM_IDENT];

	// Stream state
	logic [POS_W-1:0] pos_q;
	phase_t phase_q;
	logic [1:0] idx_q;
	logic matching_q;
	logic [POS_W-1:0] fstart_q;
	logic found_q;
	logic [POS_W-1:0] fnd_start_q;
	logic [POS_W-1:0] fnd_len_q;
	logic err_q;

	// Result register
	logic out_valid_q;
	status_t status_q;
	logic [OUT_W-1:0] mstart_q;
	logic [OUT_W-1:0] mlen_q;

	// Next-state values
	logic [POS_W-1:0] n_pos;
	phase_t n_phase;
	logic [1:0] n_idx;
	logic n_matching;
	logic [POS_W-1:0] n_fstart;
	logic n_found;
	logic [POS_W-1:0] n_fnd_start;
	logic [POS_W-1:0] n_fnd_len;
	logic n_err;
	logic do_ident;
	logic do_close;
	logic [7:0] want;
	logic ident_ok;
	status_t n_status;

	logic s1_advance;
	logic in_fire;

	// A non-final byte never produces a result; a final byte needs a free result slot.
	assign s1_advance = valid_s1 && (!final_s1 || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || s1_advance;
	assign in_fire = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	assign ident_ok = is_upper(ident_q[0]) && is_upper(ident_q[1]) && is_upper(ident_q[2]);

	always_comb begin
		case (idx_q)
			2'd0: want = ident_q[0];
			2'd1: want = ident_q[1];
			default: want = ident_q[2];
		endcase
	end

	// Parse one byte against the current stream state.
	always_comb begin
		n_pos = pos_q;
		n_phase = phase_q;
		n_idx = idx_q;
		n_matching = matching_q;
		n_fstart = fstart_q;
		n_found = found_q;
		n_fnd_start = fnd_start_q;
		n_fnd_len = fnd_len_q;
		n_err = err_q;
		do_ident = 1'b0;
		do_close = 1'b0;

		if (pos_q >= POS_W'(MAX_SUBFILE_BYTES)) begin
			// Overlong stream
			n_err = 1'b1;
		end else if (!err_q) begin
			if (final_s1) begin
				if (byte_s1 != CH_CR) begin
					n_err = 1'b1;
				end else begin
					case (phase_q)
						PH_AFTER_TYPE: ;
						PH_IDENT: if (idx_q != 2'd0) n_err = 1'b1;
						PH_DATA: do_close = 1'b1;
						default: n_err = 1'b1;
					endcase
				end
			end else begin
				case (phase_q)
					PH_TYPE1: begin
						if (is_upper(byte_s1)) n_phase = PH_TYPE2;
						else n_err = 1'b1;
					end
					PH_TYPE2: begin
						if (is_upper(byte_s1)) n_phase = PH_AFTER_TYPE;
						else n_err = 1'b1;
					end
					PH_AFTER_TYPE: begin
						// The LF after the type letters is optional.
						n_phase = PH_IDENT;
						n_idx = 2'd0;
						do_ident = (byte_s1 != CH_LF);
					end
					PH_IDENT: do_ident = 1'b1;
					PH_DATA: begin
						if (byte_s1 == CH_LF) begin
							do_close = 1'b1;
							n_phase = PH_IDENT;
							n_idx = 2'd0;
						end else if (byte_s1 < CH_PRINT_LO || byte_s1 > CH_PRINT_HI) begin
							n_err = 1'b1;
						end
					end
					default: n_err = 1'b1;
				endcase
			end

			// Identifier letter: idx_q is zero whenever we come from the type letters.
			if (do_ident) begin
				if (!is_upper(byte_s1)) begin
					n_err = 1'b1;
				end else begin
					n_matching = (idx_q == 2'd0) ? (byte_s1 == want)
						: (matching_q && (byte_s1 == want));
					if (idx_q == 2'(NUM_IDENT - 1)) begin
						n_idx = 2'd0;
						n_phase = PH_DATA;
						n_fstart = pos_q + POS_W'(1);
					end else begin
						n_idx = idx_q + 2'd1;
					end
				end
			end

			// End of a field: record a match, flag a duplicate.
			if (do_close && matching_q) begin
				if (found_q) begin
					n_err = 1'b1;
				end else begin
					n_found = 1'b1;
					n_fnd_start = fstart_q;
					n_fnd_len = pos_q - fstart_q;
				end
			end
		end

		// Saturate the position counter.
		if (pos_q < POS_W'(MAX_SUBFILE_BYTES)) n_pos = pos_q + POS_W'(1);

		if (!ident_ok) n_status = ST_BAD_IDENT;
		else if (n_err) n_status = ST_INVALID;
		else if (n_found) n_status = ST_FOUND;
		else n_status = ST_NOT_FOUND;
	end

	// Input register: hold while the byte waits for a result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= item.data_byte;
			final_s1 <= item.is_final;
		end
	end

	// Identifier registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q[0] <= IDENT_RESET;
			ident_q[1] <= IDENT_RESET;
			ident_q[2] <= IDENT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_IDENT_FIRST: ident_q[0] <= cfg.data;
				REG_IDENT_SECOND: ident_q[1] <= cfg.data;
				REG_IDENT_THIRD: ident_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Stream state: advance on every processed byte, start over after a final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_TYPE1;
			idx_q <= '0;
			matching_q <= 1'b0;
			fstart_q <= '0;
			found_q <= 1'b0;
			fnd_start_q <= '0;
			fnd_len_q <= '0;
			err_q <= 1'b0;
		end else if (s1_advance) begin
			if (final_s1) begin
				pos_q <= '0;
				phase_q <= PH_TYPE1;
				idx_q <= '0;
				matching_q <= 1'b0;
				fstart_q <= '0;
				found_q <= 1'b0;
				fnd_start_q <= '0;
				fnd_len_q <= '0;
				err_q <= 1'b0;
			end else begin
				pos_q <= n_pos;
				phase_q <= n_phase;
				idx_q <= n_idx;
				matching_q <= n_matching;
				fstart_q <= n_fstart;
				found_q <= n_found;
				fnd_start_q <= n_fnd_start;
				fnd_len_q <= n_fnd_len;
				err_q <= n_err;
			end
		end
	end

	// Result register: one transaction per final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && final_s1) begin
			status_q <= n_status;
			mstart_q <= (n_status == ST_FOUND) ? n_fnd_start[OUT_W-1:0] : '0;
			mlen_q <= (n_status == ST_FOUND) ? n_fnd_len[OUT_W-1:0] : '0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.status = status_q;
	assign result.match_start = mstart_q;
	assign result.match_length = mlen_q;

endmodule

`default_nettype wire

// ===== bench/subfile_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the ID card field locator: watches the byte, result and register channels,
// predicts the status, offset and length of each subfile and compares them with the block.
// Depends on icfl_pkg and the icfl_in_if, icfl_out_if, icfl_cfg_if interfaces.

module subfile_checker
	import icfl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	icfl_in_if item,
	icfl_out_if result,
	icfl_cfg_if cfg,
	output int pending,
	output int failures
);

	typedef struct packed {
		status_t status;
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] length;
	} located_t;

	located_t located_q[$];

	logic [7:0] wanted [NUM_IDENT];
	int unsigned byte_pos;
	int unsigned field_begin;
	int unsigned hit_begin;
	int unsigned hit_len;
	int unsigned letter_idx;
	phase_t parse_ph;
	bit letters_match;
	bit hit_seen;
	bit broken;

	function automatic bit is_capital(input logic [7:0] c);
		return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
	endfunction

	function automatic void restart_parse();
		byte_pos = 0;
		parse_ph = PH_TYPE1;
		letter_idx = 0;
		letters_match = 1'b0;
		field_begin = 0;
		hit_seen = 1'b0;
		hit_begin = 0;
		hit_len = 0;
		broken = 1'b0;
	endfunction

	// A second matching field spoils the subfile.
	function automatic void end_field(input int unsigned end_pos);
		if (!letters_match)
			return;
		if (hit_seen) begin
			broken = 1'b1;
			return;
		end
		hit_seen = 1'b1;
		hit_begin = field_begin;
		hit_len = end_pos - field_begin;
	endfunction

	function automatic void id_letter(input logic [7:0] b, input int unsigned p);
		if (!is_capital(b)) begin
			broken = 1'b1;
			return;
		end
		if (letter_idx == 0)
			letters_match = (b == wanted[0]);
		else
			letters_match = letters_match && (b == wanted[letter_idx]);
		letter_idx++;
		if (letter_idx >= NUM_IDENT) begin
			letter_idx = 0;
			parse_ph = PH_DATA;
			field_begin = p + 1;
		end
	endfunction

	function automatic void body_byte(input logic [7:0] b, input int unsigned p);
		case (parse_ph)
			PH_TYPE1: begin
				if (is_capital(b)) parse_ph = PH_TYPE2;
				else broken = 1'b1;
			end
			PH_TYPE2: begin
				if (is_capital(b)) parse_ph = PH_AFTER_TYPE;
				else broken = 1'b1;
			end
			PH_AFTER_TYPE: begin
				parse_ph = PH_IDENT;
				letter_idx = 0;
				if (b != CH_LF)
					id_letter(b, p);
			end
			PH_IDENT: id_letter(b, p);
			PH_DATA: begin
				if (b == CH_LF) begin
					end_field(p);
					parse_ph = PH_IDENT;
					letter_idx = 0;
				end else if (b < CH_PRINT_LO || b > CH_PRINT_HI) begin
					broken = 1'b1;
				end
			end
			default: broken = 1'b1;
		endcase
	endfunction

	function automatic void closing_byte(input logic [7:0] b, input int unsigned p);
		if (b != CH_CR) begin
			broken = 1'b1;
			return;
		end
		case (parse_ph)
			PH_AFTER_TYPE: ;
			PH_IDENT: if (letter_idx != 0) broken = 1'b1;
			PH_DATA: end_field(p);
			default: broken = 1'b1;
		endcase
	endfunction

	function automatic void locate_byte(input logic [7:0] b, input logic fin);
		int unsigned p;
		located_t due;
		p = byte_pos;
		if (p >= MAX_SUBFILE_BYTES)
			broken = 1'b1;
		else if (!broken) begin
			if (fin) closing_byte(b, p);
			else body_byte(b, p);
		end
		if (byte_pos < MAX_SUBFILE_BYTES)
			byte_pos++;
		if (!fin)
			return;
		if (!is_capital(wanted[0]) || !is_capital(wanted[1]) || !is_capital(wanted[2]))
			due.status = ST_BAD_IDENT;
		else if (broken)
			due.status = ST_INVALID;
		else if (hit_seen)
			due.status = ST_FOUND;
		else
			due.status = ST_NOT_FOUND;
		due.start = (due.status == ST_FOUND) ? hit_begin[OUT_W-1:0] : '0;
		due.length = (due.status == ST_FOUND) ? hit_len[OUT_W-1:0] : '0;
		located_q.push_back(due);
		restart_parse();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_IDENT; i++)
				wanted[i] = IDENT_RESET;
			restart_parse();
			located_q.delete();
			pending = 0;
			failures = 0;
		end else begin : watch
			located_t due;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_IDENT_FIRST: wanted[0] = cfg.data;
					REG_IDENT_SECOND: wanted[1] = cfg.data;
					REG_IDENT_THIRD: wanted[2] = cfg.data;
					default: ;
				endcase
			end
			if (item.valid && item.ready)
				locate_byte(item.data_byte, item.is_final);
			if (result.valid && result.ready) begin
				if (located_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: unexpected result status=%0d start=%0d length=%0d",
							$realtime, result.status, result.match_start, result.match_length);
				end else begin
					due = located_q.pop_front();
					if (result.status !== due.status || result.match_start !== due.start ||
						result.match_length !== due.length) begin
						failures++;
						if (failures <= 10) begin
							$display("%0t: result mismatch: expected status=%0d start=%0d length=%0d,",
								$realtime, due.status, due.start, due.length);
							$display("    got status=%0d start=%0d length=%0d",
								result.status, result.match_start, result.match_length);
						end
					end
				end
			end
			pending = located_q.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the ID card field locator bench: clock, reset, subfile stimulus and the verdict.
// Depends on icfl_pkg, the three channel interfaces, subfile_checker and the core.

module testbench;
	import icfl_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_BYTES = 1000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 4;
	// Index 3 addresses no register; a write to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	icfl_in_if item_ch ();
	icfl_out_if res_ch ();
	icfl_cfg_if cfg_ch ();

	int pending;
	int failures;

	id_card_field_locator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	subfile_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch),
		.pending(pending),
		.failures(failures)
	);

	// Subfile under construction, sent byte by byte.
	logic [7:0] frame[$];
	// Shadow of the identifier registers, used to build matching fields.
	logic [7:0] cur_ident [NUM_IDENT];
	bit gaps_on;
	bit rx_hold_req;
	int bytes_sent;
	int frames_sent;
	int cfg_writes;
	int cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: end the run if the block hangs or drops a result.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result receiver: random stall bursts, one long hold on request, steady ready otherwise.
	// Each branch drives ready once and then waits on falling clock edges.
	initial begin
		res_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// Offer one byte; entered and left at a falling edge. Valid stays high into the next
	// call unless a gap is drawn, so it is never dropped and raised in the same step.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data_byte <= b;
		item_ch.is_final <= fin;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Send the frame; flag the last byte as final only when the subfile is to be closed.
	task automatic send_frame(input bit close);
		for (int i = 0; i < frame.size(); i++)
			send_byte(frame[i], close && (i == frame.size() - 1));
		if (close)
			frames_sent++;
	endtask

	// Drop valid, let every expected result arrive, then give the pipeline time to empty.
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_IDENT_FIRST: cur_ident[0] = val;
			REG_IDENT_SECOND: cur_ident[1] = val;
			REG_IDENT_THIRD: cur_ident[2] = val;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic set_ident(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		write_reg(REG_IDENT_FIRST, a);
		write_reg(REG_IDENT_SECOND, b);
		write_reg(REG_IDENT_THIRD, c);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			frame.push_back(s[i]);
	endtask

	task automatic put_wanted();
		for (int i = 0; i < NUM_IDENT; i++)
			frame.push_back(cur_ident[i]);
	endtask

	task automatic put_fill(input int n);
		for (int i = 0; i < n; i++)
			frame.push_back(8'h78);
	endtask

	function automatic logic [7:0] any_capital();
		return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
	endfunction

	// Well-formed subfile with random type, optional LF, up to max_fields fields whose
	// identifiers are often the wanted one, and an occasional LF before the final CR.
	task automatic build_wellformed(input int max_fields);
		int nf;
		int dlen;
		int pick;
		frame.delete();
		frame.push_back(any_capital());
		frame.push_back(any_capital());
		if ($urandom_range(0, 1))
			frame.push_back(CH_LF);
		nf = $urandom_range(0, max_fields);
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				frame.push_back(CH_LF);
			pick = $urandom_range(0, 3);
			if (pick <= 1)
				put_wanted();
			else if (pick == 2)
				repeat (NUM_IDENT) frame.push_back(any_capital());
			else begin
				put_wanted();
				frame[frame.size() - 1 - $urandom_range(0, NUM_IDENT - 1)] = any_capital();
			end
			dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
			repeat (dlen) frame.push_back(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
		end
		if (nf > 0 && $urandom_range(0, 3) == 0)
			frame.push_back(CH_LF);
		frame.push_back(CH_CR);
	endtask

	// Well-formed subfile with one defect: a corrupted byte, a cut, or a wrong last byte.
	task automatic build_broken();
		int k;
		build_wellformed(3);
		case ($urandom_range(0, 2))
			0: frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
			1: begin
				k = $urandom_range(1, frame.size());
				while (frame.size() > k)
					void'(frame.pop_back());
				if ($urandom_range(0, 1))
					frame[frame.size() - 1] = CH_CR;
			end
			default: frame[frame.size() - 1] = 8'($urandom_range(0, 255));
		endcase
	endtask

	task automatic build_noise();
		frame.delete();
		repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		int rand_base;
		int rand_frames;
		logic [7:0] val;

		// Drive every input to a known value before reset is released.
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data_byte = 8'h00;
		item_ch.is_final = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_IDENT_FIRST;
		cfg_ch.data = 8'h00;
		rx_hold_req = 1'b0;
		gaps_on = 1'b1;
		bytes_sent = 0;
		frames_sent = 0;
		cfg_writes = 0;
		for (int i = 0; i < NUM_IDENT; i++)
			cur_ident[i] = IDENT_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset identifier AAA, found after the optional LF.
		frame.delete(); put_str("DL"); frame.push_back(CH_LF); put_str("AAAJohn Q");
		frame.push_back(CH_CR); send_frame(1);
		// Type letters only: valid, nothing found.
		frame.delete(); put_str("ID"); frame.push_back(CH_CR); send_frame(1);
		// Streams shorter than three bytes.
		frame.delete(); frame.push_back(CH_CR); send_frame(1);
		frame.delete(); put_str("A"); frame.push_back(CH_CR); send_frame(1);
		// Empty field data, then an LF right before the final CR.
		frame.delete(); put_str("DL"); frame.push_back(CH_LF); put_str("DAQ");
		frame.push_back(CH_LF); put_str("AAA"); frame.push_back(CH_LF); put_str("DCSQ");
		frame.push_back(CH_LF); frame.push_back(CH_CR); send_frame(1);
		// Identifier cut short by the final byte.
		frame.delete(); put_str("DLAA"); frame.push_back(CH_CR); send_frame(1);
		// Last byte is not CR.
		frame.delete(); put_str("DLAAAxZ"); send_frame(1);
		// Printable bounds accepted, bytes just outside them rejected.
		frame.delete(); put_str("DLAAA"); frame.push_back(CH_PRINT_LO);
		frame.push_back(CH_PRINT_HI); frame.push_back(CH_CR); send_frame(1);
		frame.delete(); put_str("DLAAA"); frame.push_back(8'h7f); frame.push_back(CH_CR);
		send_frame(1);
		frame.delete(); put_str("DLAAA"); frame.push_back(8'h1f); frame.push_back(CH_CR);
		send_frame(1);
		// Duplicate match.
		frame.delete(); put_str("DLAAA1"); frame.push_back(CH_LF); put_str("DAB2");
		frame.push_back(CH_LF); put_str("AAA3"); frame.push_back(CH_CR); send_frame(1);
		// Error early, then a matching field that must be ignored.
		frame.delete(); put_str("D1AAAok"); frame.push_back(CH_CR); send_frame(1);

		// Another identifier, found behind a field that shares its first two letters.
		set_ident("D", "A", "Q");
		frame.delete(); put_str("DL"); frame.push_back(CH_LF); put_str("DABX");
		frame.push_back(CH_LF); put_str("DAQSmith"); frame.push_back(CH_CR); send_frame(1);
		// Identifier registers outside A..Z override everything.
		write_reg(REG_IDENT_THIRD, 8'h00);
		frame.delete(); put_str("DLDAQ1"); frame.push_back(CH_CR); send_frame(1);
		write_reg(REG_IDENT_THIRD, 8'hff);
		frame.delete(); put_str("DL"); frame.push_back(CH_CR); send_frame(1);
		set_ident("@", "Z", "Z");
		frame.delete(); put_str("DLZZZ"); frame.push_back(CH_CR); send_frame(1);
		write_reg(REG_IDENT_FIRST, "[");
		frame.delete(); put_str("DLZZZ"); frame.push_back(CH_CR); send_frame(1);
		write_reg(REG_IDENT_FIRST, "Z");
		// Unused index: must leave ZZZ in place.
		write_reg(REG_UNUSED, 8'h41);
		frame.delete(); put_str("DLZZZ9"); frame.push_back(CH_CR); send_frame(1);

		// Register change mid-stream: first two letters compared with DAQ, third with Z.
		set_ident("D", "A", "Q");
		frame.delete(); put_str("DL"); frame.push_back(CH_LF); put_str("DA");
		send_frame(0);
		write_reg(REG_IDENT_THIRD, "Z");
		frame.delete(); put_str("Zok"); frame.push_back(CH_CR); send_frame(1);

		// Longest valid subfile: the CR lands on the last position.
		set_ident("A", "A", "A");
		frame.delete(); put_str("DL"); put_wanted(); put_fill(MAX_SUBFILE_BYTES - 6);
		frame.push_back(CH_CR); send_frame(1);
		// Overlong subfile, then a short one to show the state starts over.
		frame.delete(); put_str("DL"); put_wanted(); put_fill(MAX_SUBFILE_BYTES + 12);
		frame.push_back(CH_CR); send_frame(1);
		frame.delete(); put_str("DL"); put_wanted(); frame.push_back(CH_CR); send_frame(1);

		// Random part: mostly well-formed subfiles, some broken ones and some noise.
		set_ident(any_capital(), any_capital(), any_capital());
		rand_base = bytes_sent;
		rand_frames = 0;
		while (bytes_sent - rand_base < RANDOM_BYTES) begin
			// No idling in the last stretch.
			if (bytes_sent - rand_base > (RANDOM_BYTES * 4) / 5)
				gaps_on = 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				val = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : any_capital();
				write_reg(CFG_IDX_W'($urandom_range(0, NUM_IDENT - 1)), val);
			end
			if (rand_frames == 10) begin
				// Hold the receiver off while short subfiles keep coming, to back the block up.
				rx_hold_req = 1'b1;
				repeat (16) begin
					build_wellformed(1);
					send_frame(1);
				end
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: build_wellformed(3);
				7, 8: build_broken();
				default: build_noise();
			endcase
			send_frame(1);
			rand_frames++;
		end

		// Drain: every expected result in, then a wait for anything stray.
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Run covered %0d subfiles (%0d bytes) and %0d register writes,", frames_sent,
			bytes_sent, cfg_writes);
		$display("including directed edge cases, an overlong stream and a long receiver hold.");
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
